// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the interrupt router RTL.
// Expects clk_i and rst_ni in the scope of every module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge with an explicit disable term.
`define ILRC_ASSERT_DIS(lbl, dis, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (dis) (prop)) else $error(msg);

// Concurrent assertion that is switched off while the reset is applied.
`define ILRC_ASSERT(lbl, prop, msg) `ILRC_ASSERT_DIS(lbl, !rst_ni, prop, msg)

`endif

// File: hw/rtl/ilrc_pkg.sv
// Package of the interrupt line router and coalescer.
// Holds the codes, the control and result structs and the mask helper; no dependencies.
`timescale 1ns / 1ps
package ilrc_pkg;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned LINE_W    = 5;
  localparam int unsigned OWNER_W   = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned LINEOUT_W = 4;
  localparam int unsigned MISS_W    = 16;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned USERS_W   = 4;
  localparam int unsigned TOTAL_W   = 32;

  localparam logic [MASK_W-1:0]  MASK_RESET = 16'hFFFF;
  localparam logic [MISS_W-1:0]  MISS_MAX   = 16'hFFFF;
  localparam logic [USERS_W-1:0] USERS_MAX  = 4'd15;

  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER    = 3'd0,
    KIND_UNREGISTER  = 3'd1,
    KIND_INTERRUPT   = 3'd2,
    KIND_ACK         = 3'd3,
    KIND_START_CLOCK = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_BUSY    = 2'd2,
    STATUS_STRAY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_e;

  // Control from the sequencer to the shared line unit.
  typedef struct packed {
    logic              exec;  // apply the single-line operation of the held word
    logic              scan;  // apply one step of the owner release scan
    logic              load;  // capture the result into the output register
    logic [LINE_W-1:0] idx;   // line entry that the unit works on this cycle
  } ctrl_t;

  typedef struct packed {
    status_e              status;
    logic                 queued;
    logic [OWNER_W-1:0]   owner_out;
    logic [LINEOUT_W-1:0] line_out;
    logic [MISS_W-1:0]    missed_count;
    logic [MASK_W-1:0]    mask_out;
    logic [TOTAL_W-1:0]   stray_total;
    logic [TOTAL_W-1:0]   dup_total;
  } res_t;

  // One-hot mask bit of a line; lines beyond the 16-bit mask have no bit.
  function automatic logic [MASK_W-1:0] mask_bit(input logic [LINE_W-1:0] n);
    logic [MASK_W-1:0] m;
    begin
      m = '0;
      if (!n[LINE_W-1]) begin
        m[n[LINE_W-2:0]] = 1'b1;
      end
      return m;
    end
  endfunction

endpackage

// File: hw/rtl/ilrc_in_if.sv
// Input channel of the interrupt line router: valid/ready plus the request word.
// Depends on ilrc_pkg for the field widths.
`timescale 1ns / 1ps
interface ilrc_in_if import ilrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [LINE_W-1:0]  line;
  logic [OWNER_W-1:0] owner;

  modport source (output valid, kind, line, owner, input ready);
  modport sink   (input valid, kind, line, owner, output ready);
endinterface

// File: hw/rtl/ilrc_out_if.sv
// Output channel of the interrupt line router: valid/ready plus the result word.
// Depends on ilrc_pkg for the field widths.
`timescale 1ns / 1ps
interface ilrc_out_if import ilrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 queued;
  logic [OWNER_W-1:0]   owner_out;
  logic [LINEOUT_W-1:0] line_out;
  logic [MISS_W-1:0]    missed_count;
  logic [MASK_W-1:0]    mask_out;
  logic [TOTAL_W-1:0]   stray_total;
  logic [TOTAL_W-1:0]   dup_total;

  modport source (output valid, status, queued, owner_out, line_out, missed_count,
                  mask_out, stray_total, dup_total, input ready);
  modport sink   (input valid, status, queued, owner_out, line_out, missed_count,
                  mask_out, stray_total, dup_total, output ready);
endinterface

// File: hw/rtl/ilrc_seq.sv
// Sequencer of the interrupt line router: steps the shared line unit.
// Depends on ilrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ilrc_seq import ilrc_pkg::*; #(
  parameter int unsigned NUM_LINES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  kind_e             kind_i,
  input  logic [LINE_W-1:0] line_i,
  input  logic              out_free_i,
  output logic              in_ready_o,
  output ctrl_t             ctrl_o
);

  localparam int unsigned IdxW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_LINES - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          idx_d   = '0;
          state_d = (kind_i == KIND_UNREGISTER) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    ctrl_o.exec = (state_q == S_EXEC) && out_free_i;
    ctrl_o.scan = (state_q == S_SCAN);
    ctrl_o.load = ((state_q == S_EXEC) || (state_q == S_FINISH)) && out_free_i;
    ctrl_o.idx  = (state_q == S_SCAN) ? LINE_W'(idx_q) : line_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `ILRC_ASSERT(a_busy_after_accept, in_fire_i |=> !in_ready_o, "ready held after accept")
  `ILRC_ASSERT(a_scan_ends, (state_q == S_SCAN) && (idx_q == LastIdx) |=> (state_q == S_FINISH),
               "scan did not end at the last line")

endmodule

// File: hw/rtl/ilrc_table.sv
// Line table and shared line unit of the interrupt line router.
// Depends on ilrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ilrc_table import ilrc_pkg::*; #(
  parameter int unsigned NUM_LINES           = 16,
  parameter int unsigned FIRST_CASCADED_LINE = 8,
  parameter int unsigned CASCADE_LINE        = 2,
  parameter int unsigned OWNER_BITS          = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  kind_e              kind_i,
  input  logic [LINE_W-1:0]  line_i,
  input  logic [OWNER_W-1:0] owner_i,
  output res_t               res_o
);

  localparam int unsigned IdxW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int unsigned OwnW = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;

  logic               bound_q [NUM_LINES];
  logic               pend_q  [NUM_LINES];
  logic [MISS_W-1:0]  miss_q  [NUM_LINES];
  logic [OwnW-1:0]    own_q   [NUM_LINES];
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic [USERS_W-1:0] users_q, users_d;
  logic [TOTAL_W-1:0] stray_q, stray_d;
  logic [TOTAL_W-1:0] dup_q, dup_d;

  logic [IdxW-1:0]    addr;
  logic               line_ok, casc;
  logic [OwnW-1:0]    owner_m;
  logic               ent_bound, ent_pend;
  logic [MISS_W-1:0]  ent_miss, miss_inc;
  logic [OwnW-1:0]    ent_own;
  logic [MASK_W-1:0]  line_bit, casc_bit;
  logic               we, own_we, new_bound, new_pend;
  logic [MISS_W-1:0]  new_miss;

  assign addr      = ctrl_i.idx[IdxW-1:0];
  assign line_ok   = ({1'b0, line_i} < (LINE_W + 1)'(NUM_LINES));
  assign casc      = ({1'b0, ctrl_i.idx} >= (LINE_W + 1)'(FIRST_CASCADED_LINE));
  assign owner_m   = owner_i[OwnW-1:0];
  assign ent_bound = bound_q[addr];
  assign ent_pend  = pend_q[addr];
  assign ent_miss  = miss_q[addr];
  assign ent_own   = own_q[addr];
  assign miss_inc  = (ent_miss == MISS_MAX) ? ent_miss : ent_miss + 1'b1;
  assign line_bit  = mask_bit(ctrl_i.idx);
  assign casc_bit  = mask_bit(LINE_W'(CASCADE_LINE));

  always_comb begin
    res_o     = '0;
    mask_d    = mask_q;
    users_d   = users_q;
    stray_d   = stray_q;
    dup_d     = dup_q;
    we        = 1'b0;
    own_we    = 1'b0;
    new_bound = ent_bound;
    new_pend  = ent_pend;
    new_miss  = ent_miss;
    res_o.status = STATUS_OK;

    if (ctrl_i.exec) begin
      unique case (kind_i)
        KIND_REGISTER: begin
          if (!line_ok) begin
            res_o.status = STATUS_INVALID;
          end else if (ent_bound) begin
            res_o.status = STATUS_BUSY;
          end else begin
            we        = 1'b1;
            own_we    = 1'b1;
            new_bound = 1'b1;
            new_pend  = 1'b0;
            new_miss  = '0;
            mask_d    = mask_d & ~line_bit;
            if (casc) begin
              if (users_q != USERS_MAX) begin
                users_d = users_q + 1'b1;
              end
              mask_d = mask_d & ~casc_bit;
            end
          end
        end
        KIND_INTERRUPT: begin
          if (!line_ok || !ent_bound) begin
            stray_d      = stray_q + 1'b1;
            res_o.status = STATUS_STRAY;
          end else begin
            we              = 1'b1;
            res_o.owner_out = OWNER_W'(ent_own);
            if (!ent_pend) begin
              new_pend     = 1'b1;
              new_miss     = MISS_W'(1);
              res_o.queued = 1'b1;
            end else begin
              new_miss = miss_inc;
              dup_d    = dup_q + 1'b1;
            end
            res_o.missed_count = new_miss;
          end
        end
        KIND_ACK: begin
          if (!line_ok || !ent_bound) begin
            res_o.status = STATUS_INVALID;
          end else begin
            we                 = 1'b1;
            res_o.owner_out    = OWNER_W'(ent_own);
            res_o.missed_count = ent_miss;
            new_pend           = 1'b0;
            new_miss           = '0;
          end
        end
        KIND_START_CLOCK: begin
          mask_d = mask_q & ~MASK_W'(1);
        end
        default: begin
        end
      endcase
    end else if (ctrl_i.scan) begin
      // Release one line of the matching owner per step.
      if (ent_bound && (ent_own == owner_m)) begin
        we        = 1'b1;
        new_bound = 1'b0;
        new_pend  = 1'b0;
        new_miss  = '0;
        mask_d    = mask_q | line_bit;
        if (casc && (users_q != '0)) begin
          users_d = users_q - 1'b1;
          if (users_q == USERS_W'(1)) begin
            mask_d = mask_d | casc_bit;
          end
        end
      end
    end

    if (line_ok && ((kind_i == KIND_REGISTER) || (kind_i == KIND_INTERRUPT) ||
                    (kind_i == KIND_ACK))) begin
      res_o.line_out = line_i[LINEOUT_W-1:0];
    end
    res_o.mask_out    = mask_d;
    res_o.stray_total = stray_d;
    res_o.dup_total   = dup_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        bound_q[i] <= 1'b0;
        pend_q[i]  <= 1'b0;
        miss_q[i]  <= '0;
      end
      mask_q  <= MASK_RESET;
      users_q <= '0;
      stray_q <= '0;
      dup_q   <= '0;
    end else begin
      if (we) begin
        bound_q[addr] <= new_bound;
        pend_q[addr]  <= new_pend;
        miss_q[addr]  <= new_miss;
      end
      mask_q  <= mask_d;
      users_q <= users_d;
      stray_q <= stray_d;
      dup_q   <= dup_d;
    end
  end

  // Owner entries are only read while their line is bound.
  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_q[addr] <= owner_m;
    end
  end

  `ILRC_ASSERT(a_one_op, $onehot0({ctrl_i.exec, ctrl_i.scan}), "exec and scan together")
  `ILRC_ASSERT(a_one_counter, $stable(stray_q) || $stable(dup_q),
               "stray and duplicate counters moved in one cycle")

endmodule

// File: hw/rtl/interrupt_line_router_coalescer.sv
// Interrupt line router and coalescer.
// One request word on in_i (kind, line, owner) gives exactly one result word on
// out_o: status, queued flag, owner and line of the notice, miss count,
// the interrupt mask and the stray and duplicate totals after the request.
// A register, interrupt, acknowledge or start-clock word waits in the exec state
// until the output register is free; then the line unit runs and the output
// register loads the result.
// Unregister words walk every line through the same unit, one line a cycle, and
// then the finish state loads the result once the output register is free.
// in_i.ready is high only while the sequencer is idle, so one word is in work
// at a time.
// The result sits in an output register; the next word is accepted while a
// result waits. If out_o.ready stays low, the following word waits in the
// sequencer until the register frees, and nothing is lost.
// Reset (rst_ni low, asynchronous) unbinds all lines, clears pending notices
// and miss counts, masks all sixteen lines and zeroes the cascade user count
// and the stray and duplicate totals. Owner entries are not cleared; they
// are only read while their line is bound. No clearing pass is needed.
// Depends on ilrc_pkg, ilrc_in_if, ilrc_out_if, ilrc_seq, ilrc_table.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module interrupt_line_router_coalescer import ilrc_pkg::*; #(
  parameter int unsigned NUM_LINES           = 16,
  parameter int unsigned FIRST_CASCADED_LINE = 8,
  parameter int unsigned CASCADE_LINE        = 2,
  parameter int unsigned OWNER_BITS          = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilrc_in_if.sink    in_i,
  ilrc_out_if.source out_o
);

  // Held request word.
  kind_e              kind_q;
  logic [LINE_W-1:0]  line_q;
  logic [OWNER_W-1:0] owner_q;

  logic  in_fire, out_free, in_ready;
  ctrl_t ctrl;
  res_t  res, res_q;
  logic  out_valid_q, out_valid_d;

  assign in_fire  = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;

  ilrc_seq #(
    .NUM_LINES (NUM_LINES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .kind_i     (kind_e'(in_i.kind)),
    .line_i     (line_q),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl)
  );

  ilrc_table #(
    .NUM_LINES           (NUM_LINES),
    .FIRST_CASCADED_LINE (FIRST_CASCADED_LINE),
    .CASCADE_LINE        (CASCADE_LINE),
    .OWNER_BITS          (OWNER_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .kind_i  (kind_q),
    .line_i  (line_q),
    .owner_i (owner_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_e'(in_i.kind);
      line_q  <= in_i.line;
      owner_q <= in_i.owner;
    end
  end

  // Output register: loaded when the unit finishes, dropped when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.queued       = res_q.queued;
  assign out_o.owner_out    = res_q.owner_out;
  assign out_o.line_out     = res_q.line_out;
  assign out_o.missed_count = res_q.missed_count;
  assign out_o.mask_out     = res_q.mask_out;
  assign out_o.stray_total  = res_q.stray_total;
  assign out_o.dup_total    = res_q.dup_total;

  `ILRC_ASSERT(a_load_into_free, ctrl.load |-> out_free, "result loaded over a waiting word")

endmodule
